// ===== sv/exec_time_histogram_stats_top_assert.svh =====
// assertion macros for the execution-time statistics block
`ifndef EXEC_TIME_HISTOGRAM_STATS_TOP_ASSERT_SVH
`define EXEC_TIME_HISTOGRAM_STATS_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ETHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ETHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ETHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/eths_pkg.sv =====
// shared constants and beat types of the execution-time statistics block
package eths_pkg;

    localparam int unsigned FINE_RES_PCT = 5;
    localparam int unsigned COARSE_BINS  = 16;
    localparam int unsigned FINE_BINS    = (100 / FINE_RES_PCT) * 2;
    localparam int unsigned TOTAL_BINS   = FINE_BINS + COARSE_BINS;
    localparam int unsigned ADDR_W       = $clog2(TOTAL_BINS);

    // fine binning scales the duration by 200
    localparam int unsigned FINE_SCALE   = 200;

    // divider widths: fine numerator 200d + R*p, fine divisor 2*R*p
    localparam int unsigned NUM_W        = 32 + $clog2(FINE_SCALE + FINE_RES_PCT);
    localparam int unsigned DEN_W        = 33 + $clog2(FINE_RES_PCT);
    localparam int unsigned DCNT_W       = $clog2(NUM_W);

    // configuration register indexes
    localparam logic [0:0] CFG_SKIP_COUNT = 1'b0;
    localparam logic [0:0] CFG_PERIOD     = 1'b1;

    // commands
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] duration;
        logic [5:0]  read_bin;
    } t_in;

    typedef struct packed {
        logic        recorded;
        logic        overrun;
        logic        coarse;
        logic [5:0]  bin;
        logic [31:0] bin_count;
        logic [47:0] sample_count;
        logic [31:0] overrun_count;
        logic [31:0] peak_ticks;
        logic [47:0] sum_ticks;
    } t_out;

endpackage

// ===== sv/exec_time_histogram_stats_top.sv =====
// top level of the execution-time statistics unit
//
// Takes one command beat at a time: a record beat counts a measured duration,
// a read beat returns one histogram bin together with the running totals.
// Each beat yields exactly one result beat, shown for a single cycle with
// o_done high; the receiver cannot stall, so capture it on that edge.
// busy stays high from the accepting edge until the result cycle, and a new
// start may be given in the very cycle o_done is high. A read beat passes
// through S_EVAL, S_UPD and S_FIN, a record still inside the warm-up through
// S_EVAL and S_FIN, and a counted record through S_EVAL, S_DIV, S_READ, S_UPD
// and S_FIN. The counted record is dominated by the bit-serial divider that
// produces one quotient bit per cycle for the bin index; the bin then goes
// through a read, increment and write-back of the bin memory.
// All bins read as zero right after reset; there is no clearing pass.
// Configuration writes go in directly on i_cfg_we and are meant for idle
// time only.
`include "exec_time_histogram_stats_top_assert.svh"

module exec_time_histogram_stats_top
    import eths_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    // result channel
    output logic        o_done,
    output t_out        o_res,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a command beat
    localparam logic [2:0] S_EVAL = 3'd1;   // totals, warm-up check, divider launch
    localparam logic [2:0] S_DIV  = 3'd2;   // divider running
    localparam logic [2:0] S_READ = 3'd3;   // bin memory read issued
    localparam logic [2:0] S_UPD  = 3'd4;   // bin data back, write-back
    localparam logic [2:0] S_FIN  = 3'd5;   // result beat goes out

    logic [2:0]        r_state;
    t_in               r_item;

    // configuration
    logic [31:0]       r_skip;
    logic [31:0]       r_period;

    // running totals
    logic [47:0]       r_samples;
    logic [31:0]       r_overruns;
    logic [31:0]       r_longest;
    logic [47:0]       r_sum;

    // per-beat result fields
    logic              r_recorded;
    logic              r_overrun;
    logic              r_coarse;
    logic              r_in_range;
    logic [ADDR_W-1:0] r_addr;
    logic [5:0]        r_bin;
    logic [31:0]       r_count;

    logic              r_done;
    t_out              r_res;

    // datapath
    logic [31:0]       w_p;
    logic [47:0]       n_samples;
    logic              w_warmup;
    logic              w_over;
    logic              w_coarse;
    logic [48:0]       w_sum_raw;
    logic [47:0]       n_sum;
    logic [DEN_W-1:0]  w_rp;
    logic [NUM_W-1:0]  w_num;
    logic [DEN_W-1:0]  w_den;
    logic              w_div_start;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quot;
    logic [ADDR_W-1:0] n_addr;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [31:0]       w_rd_data;
    logic              w_wr_en;
    logic [31:0]       n_count;
    logic              w_rd_cmd;
    logic              w_start_ok;

    assign w_start_ok = start && (r_state == S_IDLE);
    assign w_rd_cmd   = (r_item.command == CMD_READ);

    // a zero period behaves as one tick
    assign w_p = (r_period == 32'd0) ? 32'd1 : r_period;

    // saturating sample count and warm-up test against the new count
    assign n_samples = (r_samples == '1) ? r_samples : r_samples + 48'd1;
    assign w_warmup  = (n_samples <= {16'd0, r_skip});

    assign w_over    = (r_item.duration > w_p);
    assign w_coarse  = ({1'b0, r_item.duration} > {w_p, 1'b0});

    assign w_sum_raw = {1'b0, r_sum} + {17'd0, r_item.duration};
    assign n_sum     = w_sum_raw[48] ? '1 : w_sum_raw[47:0];

    // round half up: coarse (2d + p) / 2p, fine (200d + Rp) / 2Rp
    assign w_rp = DEN_W'(w_p) * DEN_W'(FINE_RES_PCT);
    always_comb begin
        if (w_coarse) begin
            w_num = NUM_W'({r_item.duration, 1'b0}) + NUM_W'(w_p);
            w_den = DEN_W'({w_p, 1'b0});
        end else begin
            w_num = NUM_W'(r_item.duration) * NUM_W'(FINE_SCALE) + NUM_W'(w_rp);
            w_den = {w_rp[DEN_W-2:0], 1'b0};
        end
    end

    assign w_div_start = (r_state == S_EVAL) && !w_rd_cmd && !w_warmup;

    // clamp the quotient into its histogram; coarse quotients start at 2
    always_comb begin
        if (r_coarse) begin
            if (w_quot > NUM_W'(COARSE_BINS + 1)) begin
                n_addr = ADDR_W'(TOTAL_BINS - 1);
            end else begin
                n_addr = ADDR_W'(FINE_BINS) + ADDR_W'(w_quot - NUM_W'(2));
            end
        end else begin
            if (w_quot > NUM_W'(FINE_BINS - 1)) begin
                n_addr = ADDR_W'(FINE_BINS - 1);
            end else begin
                n_addr = ADDR_W'(w_quot);
            end
        end
    end

    // bin memory access: reads go out in S_EVAL for a read beat, S_READ for a record
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_addr;
        if ((r_state == S_EVAL) && w_rd_cmd && (32'(r_item.read_bin) < TOTAL_BINS)) begin
            w_rd_en   = 1'b1;
            w_rd_addr = ADDR_W'(r_item.read_bin);
        end else if (r_state == S_READ) begin
            w_rd_en = 1'b1;
        end
    end

    // one beat at a time, so the write-back always lands before the next read
    assign w_wr_en = (r_state == S_UPD) && !w_rd_cmd;
    assign n_count = (w_rd_data == '1) ? w_rd_data : w_rd_data + 32'd1;

    eths_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    eths_bin_store u_bins (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (n_count)
    );

    // sequencer, configuration and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_skip     <= 32'd0;
            r_period   <= 32'd1000;
            r_samples  <= '0;
            r_overruns <= '0;
            r_longest  <= '0;
            r_sum      <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SKIP_COUNT: r_skip   <= i_cfg_wdata;
                    CFG_PERIOD:     r_period <= i_cfg_wdata;
                    default:        r_skip   <= r_skip;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_start_ok) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_rd_cmd) begin
                        r_state <= S_UPD;
                    end else begin
                        r_samples <= n_samples;
                        if (w_warmup) begin
                            r_state <= S_FIN;
                        end else begin
                            if (w_over) begin
                                r_overruns <= (r_overruns == '1) ? r_overruns
                                                                 : r_overruns + 32'd1;
                            end
                            if (r_item.duration > r_longest) begin
                                r_longest <= r_item.duration;
                            end
                            r_sum   <= n_sum;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // beat payload and result fields
    always_ff @(posedge i_clk) begin
        if (w_start_ok) begin
            r_item <= i_item;
        end
        case (r_state)
            S_EVAL: begin
                r_count    <= 32'd0;
                r_in_range <= (32'(r_item.read_bin) < TOTAL_BINS);
                if (w_rd_cmd) begin
                    r_recorded <= 1'b0;
                    r_overrun  <= 1'b0;
                    r_coarse   <= (32'(r_item.read_bin) >= FINE_BINS) &&
                                  (32'(r_item.read_bin) < TOTAL_BINS);
                    r_bin      <= r_item.read_bin;
                end else begin
                    r_recorded <= !w_warmup;
                    r_overrun  <= !w_warmup && w_over;
                    r_coarse   <= !w_warmup && w_coarse;
                    r_bin      <= 6'd0;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_addr <= n_addr;
                    r_bin  <= 6'(n_addr);
                end
            end
            S_UPD: begin
                if (w_rd_cmd) begin
                    r_count <= r_in_range ? w_rd_data : 32'd0;
                end else begin
                    r_count <= n_count;
                end
            end
            S_FIN: begin
                r_res.recorded      <= r_recorded;
                r_res.overrun       <= r_overrun;
                r_res.coarse        <= r_coarse;
                r_res.bin           <= r_bin;
                r_res.bin_count     <= r_count;
                r_res.sample_count  <= r_samples;
                r_res.overrun_count <= r_overruns;
                r_res.peak_ticks    <= r_longest;
                r_res.sum_ticks     <= r_sum;
            end
            default: begin
                r_count <= r_count;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    // checks on the sequencer and the result beat
    `ETHS_ASSERT_NXT(a_done_single, i_clk, i_rst_n, r_done, !r_done, "result strobe held two cycles")
    `ETHS_ASSERT_NXT(a_busy_after_start, i_clk, i_rst_n, w_start_ok, busy, "accepted beat did not raise busy")
    `ETHS_ASSERT_IMP(a_overrun_recorded, i_clk, i_rst_n, r_done && r_res.overrun, r_res.recorded, "overrun flagged on an unrecorded beat")
    `ETHS_ASSERT_IMP(a_coarse_bin_range, i_clk, i_rst_n, r_done && r_res.coarse, (r_res.bin >= FINE_BINS) && (r_res.bin < TOTAL_BINS), "coarse result outside coarse bins")

endmodule

// ===== sv/eths_div.sv =====
// restoring divider, one quotient bit per cycle
module eths_div
    import eths_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_nq;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // numerator bits leave at the top, quotient bits enter at the bottom
    assign w_trial = {r_rem, r_nq[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

// ===== sv/eths_bin_store.sv =====
// histogram bin memory with per-entry valid bits, registered read
module eths_bin_store
    import eths_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [31:0]       o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data
);

    logic [31:0]           r_mem [TOTAL_BINS];
    logic [TOTAL_BINS-1:0] r_valid;
    logic [31:0]           r_rdata;
    logic                  r_rvalid;

    // an entry never written since reset reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata  <= r_mem[i_rd_addr];
            r_rvalid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rvalid ? r_rdata : 32'd0;

endmodule

// ===== test/tb_top.sv =====
// testbench for the execution-time statistics unit: directed and random commands, checked beat by beat
`timescale 1ns / 100ps

module tb_top
    import eths_pkg::*;
;

    // cycles with no accepted beat on either side before the run is declared hung;
    // the slowest step is a counted record after the longest sender gap
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // quiet time after the last result, a bit more than the longest record latency
    localparam int unsigned TAIL_CYCLES    = 64;

    // ------------------------------------------------------------------
    // running statistics of the block, kept in step with every accepted command beat
    // ------------------------------------------------------------------
    class histogram_tracker;
        logic [31:0] skip_reg      = 32'd0;
        logic [31:0] period_reg    = 32'd1000;
        logic [47:0] samples_seen  = '0;
        logic [31:0] overruns_seen = '0;
        logic [31:0] longest       = '0;
        logic [47:0] time_sum      = '0;
        logic [31:0] fine_counts[FINE_BINS];
        logic [31:0] coarse_counts[COARSE_BINS];
        t_out        awaited_results[$];
        int unsigned mismatches    = 0;

        function new();
            foreach (fine_counts[i]) fine_counts[i] = '0;
            foreach (coarse_counts[i]) coarse_counts[i] = '0;
        endfunction

        function void set_register(logic [0:0] idx, logic [31:0] value);
            if (idx == CFG_SKIP_COUNT) begin
                skip_reg = value;
            end else begin
                period_reg = value;
            end
        endfunction

        function void report_failure(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] %s", $time, what);
            end
        endfunction

        // statistics update for one command, returns the result beat it causes
        function t_out apply_command(t_in it);
            t_out        r;
            logic [63:0] p;
            logic [63:0] d;
            logic [63:0] rp;
            logic [63:0] idx;
            logic [63:0] total;
            r = '0;
            p = (period_reg == 0) ? 64'd1 : {32'd0, period_reg};
            d = {32'd0, it.duration};
            if (it.command == CMD_READ) begin
                r.bin = it.read_bin;
                if (it.read_bin < FINE_BINS) begin
                    r.bin_count = fine_counts[it.read_bin];
                end else if (it.read_bin < TOTAL_BINS) begin
                    r.coarse    = 1'b1;
                    r.bin_count = coarse_counts[it.read_bin - FINE_BINS];
                end
            end else begin
                if (samples_seen != '1) samples_seen = samples_seen + 1'b1;
                if (samples_seen > {16'd0, skip_reg}) begin
                    r.recorded = 1'b1;
                    if (d > p) begin
                        r.overrun = 1'b1;
                        if (overruns_seen != '1) overruns_seen = overruns_seen + 1'b1;
                    end
                    if (it.duration > longest) longest = it.duration;
                    total    = {16'd0, time_sum} + d;
                    time_sum = (total > 64'hFFFF_FFFF_FFFF) ? '1 : total[47:0];
                    if (d > 2 * p) begin
                        // coarse: round(d / p) - 2, half up
                        idx = (2 * d + p) / (2 * p) - 2;
                        if (idx > COARSE_BINS - 1) idx = COARSE_BINS - 1;
                        if (coarse_counts[idx] != '1) coarse_counts[idx] = coarse_counts[idx] + 1'b1;
                        r.coarse    = 1'b1;
                        r.bin       = 6'(FINE_BINS + idx);
                        r.bin_count = coarse_counts[idx];
                    end else begin
                        // fine: round(100 d / (R p)), half up
                        rp  = FINE_RES_PCT * p;
                        idx = (FINE_SCALE * d + rp) / (2 * rp);
                        if (idx > FINE_BINS - 1) idx = FINE_BINS - 1;
                        if (fine_counts[idx] != '1) fine_counts[idx] = fine_counts[idx] + 1'b1;
                        r.bin       = 6'(idx);
                        r.bin_count = fine_counts[idx];
                    end
                end
            end
            r.sample_count  = samples_seen;
            r.overrun_count = overruns_seen;
            r.peak_ticks    = longest;
            r.sum_ticks     = time_sum;
            return r;
        endfunction

        function void note_command(t_in it);
            awaited_results.push_back(apply_command(it));
        endfunction

        function void check_result(t_out got);
            t_out  want;
            string diff;
            diff = "";
            if (awaited_results.size() == 0) begin
                report_failure($sformatf("result beat with nothing outstanding: %h", got));
                return;
            end
            want = awaited_results.pop_front();
            if (got.recorded !== want.recorded)
                diff = {diff, $sformatf(" recorded %0h/%0h", want.recorded, got.recorded)};
            if (got.overrun !== want.overrun)
                diff = {diff, $sformatf(" overrun %0h/%0h", want.overrun, got.overrun)};
            if (got.coarse !== want.coarse)
                diff = {diff, $sformatf(" coarse %0h/%0h", want.coarse, got.coarse)};
            if (got.bin !== want.bin)
                diff = {diff, $sformatf(" bin %0d/%0d", want.bin, got.bin)};
            if (got.bin_count !== want.bin_count)
                diff = {diff, $sformatf(" bin_count %0h/%0h", want.bin_count, got.bin_count)};
            if (got.sample_count !== want.sample_count)
                diff = {diff, $sformatf(" sample_count %0h/%0h", want.sample_count,
                                        got.sample_count)};
            if (got.overrun_count !== want.overrun_count)
                diff = {diff, $sformatf(" overrun_count %0h/%0h", want.overrun_count,
                                        got.overrun_count)};
            if (got.peak_ticks !== want.peak_ticks)
                diff = {diff, $sformatf(" peak_ticks %0h/%0h", want.peak_ticks,
                                        got.peak_ticks)};
            if (got.sum_ticks !== want.sum_ticks)
                diff = {diff, $sformatf(" sum_ticks %0h/%0h", want.sum_ticks, got.sum_ticks)};
            if (diff != "") begin
                report_failure({"result mismatch (expected/actual):", diff});
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_in         i_item      = '0;
    logic        i_cfg_we    = 1'b0;
    logic [0:0]  i_cfg_idx   = CFG_SKIP_COUNT;
    logic [31:0] i_cfg_wdata = 32'd0;
    logic        busy;
    logic        o_done;
    t_out        o_res;

    histogram_tracker tracker;
    int unsigned      burst_left   = 0;
    int unsigned      quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    exec_time_histogram_stats_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the block's
    // own updates land, so a beat is seen exactly at the edge that takes it
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // a result in the same cycle as a new command belongs to the older one
            if (o_done === 1'b1) tracker.check_result(o_res);
            if (start === 1'b1 && busy === 1'b0) tracker.note_command(i_item);
        end
    end

    // watchdog: restarted by any beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    function automatic t_in make_command(logic cmd, logic [31:0] dur, logic [5:0] rb);
        t_in it;
        it.command  = cmd;
        it.duration = dur;
        it.read_bin = rb;
        return it;
    endfunction

    // duration spread around the period: fine range, coarse range, rounding
    // boundaries, both ends of the field and the overrun edges
    function automatic logic [31:0] pick_duration(logic [31:0] per);
        logic [63:0] p;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;
        p = (per == 0) ? 64'd1 : {32'd0, per};
        case ($urandom_range(0, 5))
            0: v = {32'd0, $urandom};
            1: v = {$urandom, $urandom} % (2 * p + 1);
            2: begin
                lo = 2 * p + 1;
                hi = 20 * p;
                v  = lo + {$urandom, $urandom} % (hi - lo + 1);
            end
            3: begin
                // half-way points of fine bins, or of coarse bins
                if ($urandom_range(0, 1) == 0)
                    v = ((2 * $urandom_range(0, 40) + 1) * p) / 40;
                else
                    v = ((2 * $urandom_range(3, 19) - 1) * p) / 2;
                v = v + $urandom_range(0, 2);
                if (v != 0) v = v - 1;
            end
            4: begin
                if ($urandom_range(0, 1) == 0)
                    v = $urandom_range(0, 3);
                else
                    v = 64'hFFFF_FFFF - $urandom_range(0, 3);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = p;
                    1:       v = p + 1;
                    2:       v = 2 * p;
                    default: v = 2 * p + 1;
                endcase
            end
        endcase
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic t_in random_command(logic [31:0] per);
        t_in it;
        it.command  = ($urandom_range(0, 9) < 3) ? CMD_READ : CMD_RECORD;
        it.duration = (it.command == CMD_READ) ? $urandom : pick_duration(per);
        it.read_bin = $urandom_range(0, 63);
        return it;
    endfunction

    // offer one command beat and hold it until taken, then keep to the burst pattern;
    // start stays high across a burst so the next beat can go in on the done cycle
    task automatic issue(t_in it);
        int unsigned gap;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop sending and wait until every outstanding result has come back
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // register writes happen only with the block idle
    task automatic write_register(logic [0:0] idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [5:0]  probe_bins[6]         = '{6'd0, 6'd39, 6'd40, 6'd55, 6'd56, 6'd63};
        logic [5:0]  touched_bins[6]       = '{6'd1, 6'd20, 6'd39, 6'd40, 6'd41, 6'd55};
        logic [31:0] boundary_durations[9] = '{32'd0, 32'd24, 32'd25, 32'd1000, 32'd1001,
                                               32'd2000, 32'd2001, 32'd2500, 32'hFFFF_FFFF};
        int unsigned beats;
        tracker = new();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, with the reset settings (no warm-up, period 1000):
        // empty bins at both ends of each histogram and past the last coarse bin
        foreach (probe_bins[i]) issue(make_command(CMD_READ, $urandom, probe_bins[i]));
        // zero, fine rounding edge, exactly one period, overrun, two periods
        // (clamped to the last fine bin), first coarse bins, largest duration
        foreach (boundary_durations[i])
            issue(make_command(CMD_RECORD, boundary_durations[i], $urandom_range(0, 63)));
        foreach (touched_bins[i]) issue(make_command(CMD_READ, $urandom, touched_bins[i]));
        wait_results_drained();

        // warm-up: the next two records only count as samples
        write_register(CFG_SKIP_COUNT, tracker.samples_seen[31:0] + 32'd2);
        issue(make_command(CMD_RECORD, 32'd1500, 6'd0));
        issue(make_command(CMD_RECORD, 32'd1500, 6'd63));
        issue(make_command(CMD_RECORD, 32'd3000, 6'd21));

        // random phases, each under its own settings
        for (int ph = 0; ph < 7; ph++) begin
            wait_results_drained();
            case (ph)
                0: begin
                    // smallest legal period
                    write_register(CFG_SKIP_COUNT, 32'd0);
                    write_register(CFG_PERIOD, 32'd1);
                    beats = 220;
                end
                1: begin
                    // zero period acts as one tick; short warm-up first
                    write_register(CFG_SKIP_COUNT, tracker.samples_seen[31:0] + 32'd15);
                    write_register(CFG_PERIOD, 32'd0);
                    beats = 200;
                end
                2: begin
                    // largest period: no record can overrun
                    write_register(CFG_SKIP_COUNT, 32'd0);
                    write_register(CFG_PERIOD, 32'hFFFF_FFFF);
                    beats = 200;
                end
                3: begin
                    // warm-up never ends
                    write_register(CFG_SKIP_COUNT, 32'hFFFF_FFFF);
                    write_register(CFG_PERIOD, 32'd777);
                    beats = 60;
                end
                4: begin
                    write_register(CFG_SKIP_COUNT, tracker.samples_seen[31:0] + 32'd40);
                    write_register(CFG_PERIOD, $urandom_range(2, 5000));
                    beats = 240;
                end
                5: begin
                    write_register(CFG_SKIP_COUNT, 32'd0);
                    write_register(CFG_PERIOD, $urandom);
                    beats = 240;
                end
                default: begin
                    write_register(CFG_SKIP_COUNT, tracker.samples_seen[31:0] + 32'd3);
                    write_register(CFG_PERIOD, 32'd1000);
                    beats = 240;
                end
            endcase
            repeat (beats) issue(random_command(tracker.period_reg));
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.awaited_results.size() != 0)
            tracker.report_failure("results still outstanding at the end");

        if (tracker.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
